// ----- rtl/d2q9c_pkg.sv -----
// ----------------------------------------------------------------------------
// D2Q9 collision core package
// Number format, saturating arithmetic helpers, lattice tables and shared types.
// ----------------------------------------------------------------------------
package d2q9c_pkg;

	localparam int W       = 32;            // word width
	localparam int F       = 24;            // fraction bits
	localparam int NDIR    = 9;             // D2Q9 directions
	localparam int DIV_LAT = W + 2;         // divider latency in cycles
	localparam int IO_BITS = 384;           // stream word width

	typedef logic signed [W-1:0] word_t;
	typedef logic [W-2:0]        uword_t;
	typedef logic signed [1:0]   dir_t;

	localparam word_t MAX_W  = {1'b0, {(W-1){1'b1}}};
	localparam word_t MIN_W  = {1'b1, {(W-1){1'b0}}};
	localparam word_t ONE    = word_t'(64'd1 << F);
	localparam word_t HALF   = word_t'(64'd1 << (F - 1));
	localparam word_t W_REST = word_t'((64'd4 << F) / 9);
	localparam word_t W_AXIS = word_t'((64'd1 << F) / 9);
	localparam word_t W_DIAG = word_t'((64'd1 << F) / 36);

	// x/3 == (x * RECIP3) >> (W+1) for any W-bit x
	localparam logic [W-1:0] RECIP3 = W'(((64'd1 << (W + 1)) + 64'd2) / 64'd3);

	localparam logic [2*W-1:0] BIG_MAG = (2*W)'(1) << W;

	localparam logic CFG_SPEED = 1'b0;
	localparam logic CFG_STEP  = 1'b1;

	localparam dir_t DIR_X [NDIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
		2'sd1, -2'sd1, -2'sd1, 2'sd1};
	localparam dir_t DIR_Y [NDIR] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
		2'sd1, 2'sd1, -2'sd1, -2'sd1};
	// weight select: rest, axis, diagonal
	localparam logic [1:0] WIDX [NDIR] = '{2'd0, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2};

	typedef struct packed {
		word_t [NDIR-1:0] f;
		uword_t           vis;
		word_t            fx;
		word_t            fy;
		word_t            rho;
		word_t            mx;
		word_t            my;
		word_t [2:0]      rw;
		word_t            u;
		word_t            v;
		word_t            tau;
		logic             pos;
	} side_t;

	function automatic logic [W-1:0] absw(input word_t a);
		logic [W-1:0] r;
		r = a;
		if (a[W-1]) r = ~r + 1'b1;
		return r;
	endfunction

	// clamp a magnitude to the word range and apply the sign
	function automatic word_t satmag(input logic [2*W-1:0] m, input logic neg);
		logic [2*W-1:0] lim;
		logic [W-1:0]   t;
		lim = neg ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - 1'b1);
		t   = (m > lim) ? lim[W-1:0] : m[W-1:0];
		if (neg) t = ~t + 1'b1;
		return word_t'(t);
	endfunction

	function automatic word_t sadd(input word_t a, input word_t b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? MIN_W : MAX_W;
		return word_t'(s[W-1:0]);
	endfunction

	function automatic word_t ssub(input word_t a, input word_t b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? MIN_W : MAX_W;
		return word_t'(s[W-1:0]);
	endfunction

	function automatic word_t smul(input word_t a, input word_t b);
		logic [2*W-1:0] p;
		p = absw(a) * absw(b);
		return satmag(p >> F, a[W-1] ^ b[W-1]);
	endfunction

endpackage

// ----- rtl/d2q9c_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Saturating signed quotient (num << F) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module d2q9c_div import d2q9c_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t num,
	input  word_t den,
	output word_t quo
);

	logic [W-1:0] na, nd, hi_ext, lo;
	logic [W-1:0] rem_s [W+1];
	logic [W-1:0] lo_s  [W+1];
	logic [W-1:0] qb_s  [W+1];
	logic [W-1:0] den_s [W+1];
	logic         neg_s [W+1];
	logic         ovf_s [W+1];
	logic [W:0]   trial [W];
	logic [W:0]   diff  [W];
	logic         take  [W];
	word_t        quo_s;

	always_comb begin
		na     = absw(num);
		nd     = absw(den);
		hi_ext = {{(W-F){1'b0}}, na[W-1:W-F]};
		lo     = {na[W-F-1:0], {F{1'b0}}};
	end

	always_comb begin
		for (int i = 0; i < W; i++) begin
			trial[i] = {rem_s[i], lo_s[i][W-1]};
			take[i]  = trial[i] >= {1'b0, den_s[i]};
			diff[i]  = take[i] ? trial[i] - {1'b0, den_s[i]} : trial[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient needs more than W bits when the upper dividend part reaches den
			rem_s[0] <= hi_ext;
			lo_s[0]  <= lo;
			qb_s[0]  <= '0;
			den_s[0] <= (nd == '0) ? '1 : nd;   // zero over zero gives zero
			neg_s[0] <= num[W-1] ^ den[W-1];
			ovf_s[0] <= (hi_ext >= nd) && (na != '0);
			for (int i = 0; i < W; i++) begin
				rem_s[i+1] <= diff[i][W-1:0];
				lo_s[i+1]  <= lo_s[i] << 1;
				qb_s[i+1]  <= {qb_s[i][W-2:0], take[i]};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
			quo_s <= satmag(ovf_s[W] ? BIG_MAG : {{W{1'b0}}, qb_s[W]}, neg_s[W]);
		end
	end

	assign quo = quo_s;

endmodule

// ----- rtl/d2q9_bgk_node_collision_core.sv -----
// ----------------------------------------------------------------------------
// D2Q9 BGK node collision core
// Density, velocity, relaxation time and nine post-collision distributions.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one lattice node per word (nine distributions,
//   viscosity, body force). Output stream m_axis: nine post-collision
//   distributions, density and velocity, one word per node, in order.
//   cfg channel writes lattice speed (index 0) and time step (index 1);
//   cfg_ready is always high. Write only while the core is empty.
// Datapath: input accept to output valid runs through a chain of six
//   pipelined dividers plus the multiply and add stages.
// Throughput: one node per cycle unless the output stalls; every stage advances together.
// Reset: all valid bits clear, speed and time step return to 1.0; the
//   derived cs2 value passes through cc_q, cp_q and cs2_q after reset or a write.
// Stall: a skid word behind the output register catches the word in flight;
//   once it is full, s_axis_tready drops and the whole pipeline holds.
// Density not positive: velocity is zero and distributions pass unchanged.
// ----------------------------------------------------------------------------
module d2q9_bgk_node_collision_core import d2q9c_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// dist_rest, dist_east, dist_north, dist_west, dist_south, dist_northeast,
	// dist_northwest, dist_southwest, dist_southeast, node_viscosity, force_x,
	// force_y, one zero pad bit
	input  logic [IO_BITS-1:0] s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// post_rest .. post_southeast, node_density, velocity_x, velocity_y
	output logic [IO_BITS-1:0] m_axis_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  uword_t             cfg_data
);

	logic   en;
	uword_t speed_q, step_q;
	word_t  c_w, dt_w;
	logic [W-1:0]   cc_q;
	logic [2*W-1:0] cp_q;
	word_t  cs2_q;

	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	side_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t dla_s [DIV_LAT];
	side_t dlb_s [DIV_LAT];
	side_t dlc_s [DIV_LAT];
	side_t dld_s [DIV_LAT];
	side_t dle_s [DIV_LAT];
	side_t dlf_s [DIV_LAT];
	logic [DIV_LAT-1:0] vla_s, vlb_s, vlc_s, vld_s, vle_s, vlf_s;
	side_t sd_b_in;
	side_t sd_s108, sd_s109, sd_s110;
	side_t nx_s108, nx_s109, nx_s110;
	logic  v_s108, v_s109, v_s110;
	side_t sd_s145, sd_s146, sd_s147;
	logic  v_s145, v_s146, v_s147;
	word_t ue_s145, ve_s145, uq_s146, vq_s146, uu_s147;
	word_t [NDIR-1:0] e_nx, e_s146, ec_s147;
	side_t sd_s182, sd_s183, sd_s184, sd_s185, sd_s186, sd_s187;
	logic  v_s182, v_s183, v_s184, v_s185, v_s186, v_s187;
	word_t t3_s182, t3_s183, t3_s184;
	word_t [NDIR-1:0] rr_s182, a_s182, hrr_s183, a_s183, b_s184, br_s185;
	word_t [NDIR-1:0] feq_s186, dn_s187;
	word_t u_div, v_div, q1_div, q2_div, q3_div, gx_div, gy_div, uuq_div;
	word_t r_div  [NDIR];
	word_t pq_div [NDIR];
	side_t sd_fin;
	word_t [NDIR-1:0] post_nx;
	word_t vx_nx, vy_nx;
	logic [IO_BITS-1:0] fin_s222, skid_q, tdata_q;
	logic  v_s222, skid_v_q, tvalid_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign c_w           = word_t'({1'b0, speed_q});
	assign dt_w          = word_t'({1'b0, step_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= uword_t'(ONE);
			step_q  <= uword_t'(ONE);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SPEED: speed_q <= cfg_data;
				CFG_STEP:  step_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// cs2 = c*c/3, recomputed every cycle from the registers
	always_ff @(posedge clk) begin
		cc_q  <= smul(c_w, c_w);
		cp_q  <= cc_q * RECIP3;
		cs2_q <= word_t'(cp_q >> (W + 1));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
			{vla_s, vlb_s, vlc_s, vld_s, vle_s, vlf_s} <= '0;
			{v_s108, v_s109, v_s110, v_s145, v_s146, v_s147} <= '0;
			{v_s182, v_s183, v_s184, v_s185, v_s186, v_s187, v_s222} <= '0;
		end else if (en) begin
			v_s1   <= s_axis_tvalid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			vla_s  <= {vla_s[DIV_LAT-2:0], v_s5};
			vlb_s  <= {vlb_s[DIV_LAT-2:0], vla_s[DIV_LAT-1]};
			vlc_s  <= {vlc_s[DIV_LAT-2:0], vlb_s[DIV_LAT-1]};
			v_s108 <= vlc_s[DIV_LAT-1];
			v_s109 <= v_s108;
			v_s110 <= v_s109;
			vld_s  <= {vld_s[DIV_LAT-2:0], v_s110};
			v_s145 <= vld_s[DIV_LAT-1];
			v_s146 <= v_s145;
			v_s147 <= v_s146;
			vle_s  <= {vle_s[DIV_LAT-2:0], v_s147};
			v_s182 <= vle_s[DIV_LAT-1];
			v_s183 <= v_s182;
			v_s184 <= v_s183;
			v_s185 <= v_s184;
			v_s186 <= v_s185;
			v_s187 <= v_s186;
			vlf_s  <= {vlf_s[DIV_LAT-2:0], v_s187};
			v_s222 <= vlf_s[DIV_LAT-1];
		end
	end

	// unpack, density and momentum sums in the listed order, then scaling
	always_comb begin
		nx_s1 = '0;
		for (int n = 0; n < NDIR; n++) nx_s1.f[n] = word_t'(s_axis_tdata[n*W +: W]);
		nx_s1.vis = s_axis_tdata[NDIR*W +: W-1];
		nx_s1.fx  = word_t'(s_axis_tdata[NDIR*W+W-1 +: W]);
		nx_s1.fy  = word_t'(s_axis_tdata[NDIR*W+2*W-1 +: W]);

		nx_s2     = sd_s1;
		nx_s2.rho = sadd(sadd(sd_s1.f[0], sd_s1.f[1]), sd_s1.f[2]);
		nx_s2.mx  = ssub(sd_s1.f[1], sd_s1.f[3]);
		nx_s2.my  = ssub(sd_s1.f[2], sd_s1.f[4]);

		nx_s3     = sd_s2;
		nx_s3.rho = sadd(sadd(sadd(sd_s2.rho, sd_s2.f[3]), sd_s2.f[4]), sd_s2.f[5]);
		nx_s3.mx  = ssub(sadd(sd_s2.mx, sd_s2.f[5]), sd_s2.f[6]);
		nx_s3.my  = sadd(sadd(sd_s2.my, sd_s2.f[5]), sd_s2.f[6]);

		nx_s4     = sd_s3;
		nx_s4.rho = sadd(sadd(sadd(sd_s3.rho, sd_s3.f[6]), sd_s3.f[7]), sd_s3.f[8]);
		nx_s4.mx  = sadd(ssub(sd_s3.mx, sd_s3.f[7]), sd_s3.f[8]);
		nx_s4.my  = ssub(ssub(sd_s3.my, sd_s3.f[7]), sd_s3.f[8]);

		nx_s5       = sd_s4;
		nx_s5.pos   = !sd_s4.rho[W-1] && (sd_s4.rho != '0);
		nx_s5.mx    = smul(sd_s4.mx, c_w);
		nx_s5.my    = smul(sd_s4.my, c_w);
		nx_s5.rw[0] = smul(sd_s4.rho, W_REST);
		nx_s5.rw[1] = smul(sd_s4.rho, W_AXIS);
		nx_s5.rw[2] = smul(sd_s4.rho, W_DIAG);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= nx_s1;
			sd_s2 <= nx_s2;
			sd_s3 <= nx_s3;
			sd_s4 <= nx_s4;
			sd_s5 <= nx_s5;
		end
	end

	// velocity and vis/rho
	d2q9c_div u_div_u  (.clk(clk), .en(en), .num(sd_s5.mx), .den(sd_s5.rho), .quo(u_div));
	d2q9c_div u_div_v  (.clk(clk), .en(en), .num(sd_s5.my), .den(sd_s5.rho), .quo(v_div));
	d2q9c_div u_div_q1 (.clk(clk), .en(en), .num(word_t'({1'b0, sd_s5.vis})),
		.den(sd_s5.rho), .quo(q1_div));

	always_comb begin
		sd_b_in   = dla_s[DIV_LAT-1];
		sd_b_in.u = u_div;
		sd_b_in.v = v_div;
	end

	d2q9c_div u_div_q2 (.clk(clk), .en(en), .num(q1_div), .den(cs2_q), .quo(q2_div));
	d2q9c_div u_div_q3 (.clk(clk), .en(en), .num(q2_div), .den(dt_w), .quo(q3_div));

	always_ff @(posedge clk) begin
		if (en) begin
			dla_s[0] <= sd_s5;
			dlb_s[0] <= sd_b_in;
			dlc_s[0] <= dlb_s[DIV_LAT-1];
			dld_s[0] <= sd_s110;
			dle_s[0] <= sd_s147;
			dlf_s[0] <= sd_s187;
			for (int i = 1; i < DIV_LAT; i++) begin
				dla_s[i] <= dla_s[i-1];
				dlb_s[i] <= dlb_s[i-1];
				dlc_s[i] <= dlc_s[i-1];
				dld_s[i] <= dld_s[i-1];
				dle_s[i] <= dle_s[i-1];
				dlf_s[i] <= dlf_s[i-1];
			end
		end
	end

	// tau and the force shift tau*f*dt
	always_comb begin
		nx_s108     = dlc_s[DIV_LAT-1];
		nx_s108.tau = sadd(q3_div, HALF);
		nx_s109     = sd_s108;
		nx_s109.fx  = smul(sd_s108.tau, sd_s108.fx);
		nx_s109.fy  = smul(sd_s108.tau, sd_s108.fy);
		nx_s110     = sd_s109;
		nx_s110.fx  = smul(sd_s109.fx, dt_w);
		nx_s110.fy  = smul(sd_s109.fy, dt_w);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s108 <= nx_s108;
			sd_s109 <= nx_s109;
			sd_s110 <= nx_s110;
		end
	end

	d2q9c_div u_div_gx (.clk(clk), .en(en), .num(sd_s110.fx), .den(sd_s110.rho), .quo(gx_div));
	d2q9c_div u_div_gy (.clk(clk), .en(en), .num(sd_s110.fy), .den(sd_s110.rho), .quo(gy_div));

	// projection of the shifted velocity on each lattice direction
	always_comb begin
		for (int n = 0; n < NDIR; n++) begin
			e_nx[n] = '0;
			if (DIR_X[n] > 0)      e_nx[n] = sadd(e_nx[n], ue_s145);
			else if (DIR_X[n] < 0) e_nx[n] = ssub(e_nx[n], ue_s145);
			if (DIR_Y[n] > 0)      e_nx[n] = sadd(e_nx[n], ve_s145);
			else if (DIR_Y[n] < 0) e_nx[n] = ssub(e_nx[n], ve_s145);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s145 <= dld_s[DIV_LAT-1];
			ue_s145 <= sadd(dld_s[DIV_LAT-1].u, gx_div);
			ve_s145 <= sadd(dld_s[DIV_LAT-1].v, gy_div);
			sd_s146 <= sd_s145;
			uq_s146 <= smul(ue_s145, ue_s145);
			vq_s146 <= smul(ve_s145, ve_s145);
			e_s146  <= e_nx;
			sd_s147 <= sd_s146;
			uu_s147 <= sadd(uq_s146, vq_s146);
			for (int n = 0; n < NDIR; n++) ec_s147[n] <= smul(e_s146[n], c_w);
		end
	end

	d2q9c_div u_div_uu (.clk(clk), .en(en), .num(uu_s147), .den(cs2_q), .quo(uuq_div));

	for (genvar n = 0; n < NDIR; n++) begin : g_dir
		d2q9c_div u_div_r (.clk(clk), .en(en), .num(ec_s147[n]), .den(cs2_q),
			.quo(r_div[n]));
		d2q9c_div u_div_p (.clk(clk), .en(en), .num(dn_s187[n]), .den(sd_s187.tau),
			.quo(pq_div[n]));
	end

	// equilibrium polynomial and relaxation difference
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s182 <= dle_s[DIV_LAT-1];
			t3_s182 <= smul(HALF, uuq_div);
			sd_s183 <= sd_s182;
			t3_s183 <= t3_s182;
			sd_s184 <= sd_s183;
			t3_s184 <= t3_s183;
			sd_s185 <= sd_s184;
			sd_s186 <= sd_s185;
			sd_s187 <= sd_s186;
			for (int n = 0; n < NDIR; n++) begin
				rr_s182[n]  <= smul(r_div[n], r_div[n]);
				a_s182[n]   <= sadd(ONE, r_div[n]);
				hrr_s183[n] <= smul(HALF, rr_s182[n]);
				a_s183[n]   <= a_s182[n];
				b_s184[n]   <= sadd(a_s183[n], hrr_s183[n]);
				br_s185[n]  <= ssub(b_s184[n], t3_s184);
				feq_s186[n] <= smul(sd_s185.rw[WIDX[n]], br_s185[n]);
				dn_s187[n]  <= ssub(sd_s186.f[n], feq_s186[n]);
			end
		end
	end

	// final select: non-positive density passes the node through
	always_comb begin
		sd_fin = dlf_s[DIV_LAT-1];
		for (int n = 0; n < NDIR; n++)
			post_nx[n] = sd_fin.pos ? ssub(sd_fin.f[n], pq_div[n]) : sd_fin.f[n];
		vx_nx = sd_fin.pos ? sd_fin.u : '0;
		vy_nx = sd_fin.pos ? sd_fin.v : '0;
	end

	always_ff @(posedge clk) begin
		if (en) fin_s222 <= {vy_nx, vx_nx, sd_fin.rho, post_nx};
	end

	// output register with skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (tvalid_q && !m_axis_tready) begin
			if (en && v_s222) skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			tvalid_q <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			tvalid_q <= v_s222;
		end
	end

	always_ff @(posedge clk) begin
		if (tvalid_q && !m_axis_tready) begin
			if (en && v_s222) skid_q <= fin_s222;
		end else if (skid_v_q) begin
			tdata_q <= skid_q;
		end else begin
			tdata_q <= fin_s222;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(tvalid_q && !m_axis_tready))
		else $error("skid filled without an output stall");

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> tvalid_q)
		else $error("skid word held while output empty");

	a_zero_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[319] || (m_axis_tdata[319:288] == '0)))
		|-> (m_axis_tdata[383:320] == '0))
		else $error("nonzero velocity for non-positive density");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// D2Q9 BGK collision core testbench
// Streams lattice nodes through the core with random gaps and output stalls,
// predicts each result word in fixed point and checks every field in order.
// ----------------------------------------------------------------------------
module testbench import d2q9c_pkg::*; ();

	localparam int      NFIELD = 12;
	localparam int      SETTLE = 240;     // core latency plus margin
	localparam longint  LIMIT  = 600000;
	localparam longint  FONE   = 64'd1 << 24;

	typedef struct {
		word_t  f[9];
		uword_t vis;
		word_t  fx;
		word_t  fy;
	} node_t;

	typedef struct {
		word_t v[NFIELD];
	} post_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IO_BITS-1:0] s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b1;
	logic [IO_BITS-1:0] m_axis_tdata;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = CFG_SPEED;
	uword_t             cfg_data = '0;

	post_t  post_q[$];
	longint speed_q = FONE;
	longint step_q = FONE;
	int     errs = 0;
	longint cycles = 0;
	bit     tx_idle = 1'b1;
	bit     rx_idle = 1'b1;

	string  fname[NFIELD] = '{"post_rest", "post_east", "post_north", "post_west",
		"post_south", "post_northeast", "post_northwest", "post_southwest",
		"post_southeast", "node_density", "velocity_x", "velocity_y"};
	int     dx[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	int     dy[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

	d2q9_bgk_node_collision_core u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ---- fixed point arithmetic, saturating to 32 bits ----
	function automatic longint clampw(longint s);
		if (s > 64'sh7fff_ffff) return 64'sh7fff_ffff;
		if (s < -64'sh8000_0000) return -64'sh8000_0000;
		return s;
	endfunction

	function automatic longint unsigned magn(longint a);
		return a < 0 ? longint'(-a) : a;
	endfunction

	function automatic longint clampmag(longint unsigned m, bit neg);
		longint unsigned lim;
		lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
		if (m > lim) m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint qadd(longint a, longint b);
		return clampw(a + b);
	endfunction

	function automatic longint qsub(longint a, longint b);
		return clampw(a - b);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clampmag((magn(a) * magn(b)) >> 24, (a < 0) != (b < 0));
	endfunction

	function automatic longint qdiv(longint a, longint b);
		if (b == 0) return a == 0 ? 0 : (a < 0 ? -64'sh8000_0000 : 64'sh7fff_ffff);
		return clampmag((magn(a) << 24) / magn(b), (a < 0) != (b < 0));
	endfunction

	// ---- collision predictor ----
	function automatic post_t collide(node_t nd);
		post_t  r;
		longint rho, mx, my, u, v, cs2, tau, ueq, veq, uu, t3;
		longint e, rr, br, w, feq, half;
		rho = 0; mx = 0; my = 0; u = 0; v = 0;
		half = FONE >> 1;
		for (int n = 0; n < 9; n++) rho = qadd(rho, nd.f[n]);
		if (rho <= 0) begin
			for (int n = 0; n < 9; n++) r.v[n] = nd.f[n];
		end else begin
			cs2 = qdiv(qmul(speed_q, speed_q), 3 * FONE);
			for (int n = 1; n < 9; n++) begin
				if (dx[n] > 0) mx = qadd(mx, nd.f[n]);
				else if (dx[n] < 0) mx = qsub(mx, nd.f[n]);
				if (dy[n] > 0) my = qadd(my, nd.f[n]);
				else if (dy[n] < 0) my = qsub(my, nd.f[n]);
			end
			u = qdiv(qmul(mx, speed_q), rho);
			v = qdiv(qmul(my, speed_q), rho);
			tau = qadd(qdiv(qdiv(qdiv(longint'(nd.vis), rho), cs2), step_q), half);
			ueq = qadd(u, qdiv(qmul(qmul(tau, nd.fx), step_q), rho));
			veq = qadd(v, qdiv(qmul(qmul(tau, nd.fy), step_q), rho));
			uu = qadd(qmul(ueq, ueq), qmul(veq, veq));
			t3 = qmul(half, qdiv(uu, cs2));
			for (int n = 0; n < 9; n++) begin
				e = 0;
				if (dx[n] > 0) e = qadd(e, ueq);
				else if (dx[n] < 0) e = qsub(e, ueq);
				if (dy[n] > 0) e = qadd(e, veq);
				else if (dy[n] < 0) e = qsub(e, veq);
				rr = qdiv(qmul(e, speed_q), cs2);
				br = qsub(qadd(qadd(FONE, rr), qmul(half, qmul(rr, rr))), t3);
				w = n == 0 ? (4 * FONE) / 9 : (n < 5 ? FONE / 9 : FONE / 36);
				feq = qmul(qmul(rho, w), br);
				r.v[n] = word_t'(qsub(nd.f[n], qdiv(qsub(nd.f[n], feq), tau)));
			end
		end
		r.v[9] = word_t'(rho);
		r.v[10] = word_t'(u);
		r.v[11] = word_t'(v);
		return r;
	endfunction

	// ---- sender ----
	task automatic send_node(node_t nd);
		int gap;
		logic [IO_BITS-1:0] d;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		d = '0;
		for (int n = 0; n < 9; n++) d[32*n +: 32] = nd.f[n];
		d[288 +: 31] = nd.vis;
		d[319 +: 32] = nd.fx;
		d[351 +: 32] = nd.fy;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		post_q.push_back(collide(nd));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (post_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, uword_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SPEED) speed_q = val;
		else step_q = val;
		repeat (8) @(posedge clk);    // derived cs2 settles
	endtask

	// ---- node generators ----
	function automatic node_t wild_node();
		node_t nd;
		for (int n = 0; n < 9; n++) nd.f[n] = $urandom;
		nd.vis = uword_t'($urandom);
		nd.fx = $urandom;
		nd.fy = $urandom;
		return nd;
	endfunction

	// plausible fluid node: positive density near one, small force
	function automatic node_t fluid_node();
		node_t nd;
		for (int n = 0; n < 9; n++) nd.f[n] = $urandom_range(0, 32'h0040_0000);
		nd.vis = uword_t'($urandom_range(0, 32'h0100_0000));
		nd.fx = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		nd.fy = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		return nd;
	endfunction

	function automatic node_t flat_node(word_t fv, uword_t vis, word_t fx, word_t fy);
		node_t nd;
		foreach (nd.f[n]) nd.f[n] = fv;
		nd.vis = vis;
		nd.fx = fx;
		nd.fy = fy;
		return nd;
	endfunction

	// ---- result checker and output stalls ----
	always @(posedge clk) begin
		post_t ex;
		if (m_axis_tvalid && m_axis_tready) begin
			if (post_q.size() == 0) begin
				$error("result word with nothing expected");
				errs++;
			end else begin
				ex = post_q.pop_front();
				for (int i = 0; i < NFIELD; i++)
					if (m_axis_tdata[32*i +: 32] !== ex.v[i]) begin
						$error("%s: expected %h, got %h", fname[i], ex.v[i],
							m_axis_tdata[32*i +: 32]);
						errs++;
					end
			end
		end
	end

	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready && rx_idle) begin
				n = $urandom_range(0, 13);
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// ---- tests ----
	task automatic test_extremes();
		node_t nd;
		send_node(flat_node(32'sh7fff_ffff, 31'h7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		send_node(flat_node(-32'sh8000_0000, 31'h7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff));
		send_node(flat_node('0, '0, '0, '0));                          // zero density
		send_node(flat_node(-32'sh0010_0000, 31'h10_0000, 32'sh1000, -32'sh1000)); // negative
		send_node(flat_node(32'sh001c_71c7, '0, '0, '0));              // fluid at rest
		send_node(flat_node(32'sh001c_71c7, 31'h7fff_ffff, 32'sh7fff_ffff, -32'sh8000_0000));
		send_node(flat_node(32'sh0000_0001, 31'h1, 32'sh1, -32'sh1));  // tiny density
		nd = fluid_node();
		nd.f[0] = 32'sh7fff_ffff;
		send_node(nd);
		nd = fluid_node();
		nd.f[1] = 32'sh7000_0000; nd.f[5] = 32'sh7000_0000;            // momentum saturates
		send_node(nd);
		nd = fluid_node();
		nd.f[3] = 32'sh0100_0000; nd.f[4] = -32'sh00f0_0000;
		send_node(nd);
		nd = fluid_node();
		nd.f[0] = -32'sh0010_0000;                                     // rho exactly zero
		foreach (nd.f[k]) if (k != 0) nd.f[k] = 32'sh0002_0000;
		send_node(nd);
		drain();
	endtask

	task automatic run_random(int count, int wild_pct);
		for (int i = 0; i < count; i++)
			send_node($urandom_range(0, 99) < wild_pct ? wild_node() : fluid_node());
	endtask

	task automatic test_settings();
		uword_t spd[5] = '{31'h1, 31'h7fff_ffff, 31'h0080_0000, 31'h0000_0000, 31'h0100_0000};
		uword_t stp[5] = '{31'h7fff_ffff, 31'h1, 31'h0200_0000, 31'h0100_0000, 31'h0};
		for (int k = 0; k < 5; k++) begin
			write_reg(CFG_SPEED, spd[k]);
			write_reg(CFG_STEP, stp[k]);
			run_random(60, 30);
			drain();
		end
		write_reg(CFG_SPEED, 31'h0100_0000);
		write_reg(CFG_STEP, 31'h0100_0000);
	endtask

	task automatic test_streaming();
		run_random(400, 20);
		// full rate both ways
		tx_idle = 1'b0; rx_idle = 1'b0;
		run_random(300, 20);
		rx_idle = 1'b1;
		run_random(200, 20);
		// sender holds off until the pipeline has emptied
		s_axis_tvalid <= 1'b0;
		while (post_q.size() != 0) @(posedge clk);
		tx_idle = 1'b1;
		run_random(300, 25);
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (8) @(posedge clk);
		test_extremes();
		test_settings();
		test_streaming();
		if (errs == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

endmodule
